/* hw/rtl/pfba_pkg.sv */
`default_nettype none

package pfba_pkg;

   localparam int PAGE_COUNT = 512;
   localparam int WORD_BITS = 32;
   localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = $clog2(MAP_WORDS);
   localparam int OFF_W     = $clog2(WORD_BITS);
   localparam int PAGE_W    = 9;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // register select is address bit 2
   localparam logic REG_OS_LAST  = 1'b0;
   localparam logic REG_MEM_LAST = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FREE,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WORD_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [WORD_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_port_type;

endpackage

`default_nettype wire

/* hw/rtl/pfba_ifs.sv */
`default_nettype none

interface pfba_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [8:0] page;

   modport source (output valid, output kind, output page, input ready);
   modport sink   (input valid, input kind, input page, output ready);
endinterface

interface pfba_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [8:0] alloc_page;

   modport source (output valid, output status, output alloc_page, input ready);
   modport sink   (input valid, input status, input alloc_page, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pfba_csr.sv */
`default_nettype none

module pfba_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [pfba_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [pfba_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [pfba_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready,
   output logic      [pfba_pkg::PAGE_W-1:0]  os_last_page,
   output logic      [pfba_pkg::PAGE_W-1:0]  mem_last_page
);
   import pfba_pkg::*;

   logic [PAGE_W-1:0] os_last_ff, os_last_in;
   logic [PAGE_W-1:0] mem_last_ff, mem_last_in;
   logic              wr_fire;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      os_last_in  = os_last_ff;
      mem_last_in = mem_last_ff;
      if (wr_fire) begin
         unique case (csr_paddr[2])
            REG_OS_LAST:  os_last_in  = csr_pwdata[PAGE_W-1:0];
            REG_MEM_LAST: mem_last_in = csr_pwdata[PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_OS_LAST:  csr_prdata = CSR_DW'(os_last_ff);
         REG_MEM_LAST: csr_prdata = CSR_DW'(mem_last_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         os_last_ff  <= '0;
         mem_last_ff <= PAGE_W'(PAGE_COUNT - 1);
      end else begin
         os_last_ff  <= os_last_in;
         mem_last_ff <= mem_last_in;
      end
   end

   assign os_last_page  = os_last_ff;
   assign mem_last_page = mem_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/pfba_map_ram.sv */
`default_nettype none

module pfba_map_ram (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pfba_pkg::map_port_type          map_port,
   output logic      [pfba_pkg::WORD_BITS-1:0]  rd_data
);
   import pfba_pkg::*;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (map_port.wr_en) begin
         mem[map_port.wr_addr] <= map_port.wr_data;
      end
      if (map_port.rd_en) begin
         rd_word_ff <= mem[map_port.rd_addr];
      end
   end

   // a word never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (map_port.wr_en) begin
            valid_ff[map_port.wr_addr] <= 1'b1;
         end
         if (map_port.rd_en) begin
            rd_valid_ff <= valid_ff[map_port.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

/* hw/rtl/pfba_ctrl.sv */
`default_nettype none

module pfba_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pfba_req_if.sink                             req,
   pfba_rsp_if.source                           rsp,
   input  wire logic [pfba_pkg::PAGE_W-1:0]     os_last_page,
   input  wire logic [pfba_pkg::PAGE_W-1:0]     mem_last_page,
   output pfba_pkg::map_port_type               map_port,
   input  wire logic [pfba_pkg::WORD_BITS-1:0]  rd_data
);
   import pfba_pkg::*;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] off;
   } find_type;

   // lowest free page in a word: highest set bit of free_bits, per byte then across bytes
   function automatic find_type find_first_free(input logic [WORD_BITS-1:0] free_bits);
      find_type   r;
      logic [3:0] byte_hit;
      logic [2:0] byte_off [4];
      r = '0;
      for (int b = 0; b < 4; b++) begin
         byte_hit[b] = 1'b0;
         byte_off[b] = '0;
         for (int j = 7; j >= 0; j--) begin
            if (free_bits[WORD_BITS - 1 - (8 * b + j)]) begin
               byte_hit[b] = 1'b1;
               byte_off[b] = 3'(j);
            end
         end
      end
      for (int b = 3; b >= 0; b--) begin
         if (byte_hit[b]) begin
            r.found = 1'b1;
            r.off   = {2'(b), byte_off[b]};
         end
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic               res_status_ff, res_status_in;
   logic [PAGE_W-1:0]  res_page_ff, res_page_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]  rsp_page_ff, rsp_page_in;

   logic [PAGE_W:0]      start_page;
   logic [WORD_BITS-1:0] lead_mask;
   logic [WORD_BITS-1:0] masked;
   find_type             hit;
   logic [PAGE_W-1:0]    hit_page;

   assign start_page = {1'b0, os_last_page} + (PAGE_W + 1)'(1);
   assign lead_mask  = ~(WORD_ONES >> start_page[OFF_W-1:0]);
   // reserved pages in the first word read as used
   assign masked     = (word_ff == start_page[OFF_W +: WORD_W]) ? (rd_data | lead_mask)
                                                                 : rd_data;
   assign hit        = find_first_free(~masked);
   assign hit_page   = {word_ff, hit.off};

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      word_in       = word_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      map_port      = '0;
      req.ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               page_in       = req.page;
               res_status_in = STATUS_OK;
               res_page_in   = '0;
               if (req.kind == KIND_FREE) begin
                  map_port.rd_en   = 1'b1;
                  map_port.rd_addr = req.page[OFF_W +: WORD_W];
                  state_in         = S_FREE;
               end else if (start_page >= (PAGE_W + 1)'(PAGE_COUNT)) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_RESP;
               end else begin
                  map_port.rd_en   = 1'b1;
                  map_port.rd_addr = start_page[OFF_W +: WORD_W];
                  word_in          = start_page[OFF_W +: WORD_W];
                  state_in         = S_SCAN;
               end
            end
         end
         S_FREE: begin
            map_port.wr_en   = 1'b1;
            map_port.wr_addr = page_ff[OFF_W +: WORD_W];
            map_port.wr_data = rd_data & ~(WORD_ONES & ~(WORD_ONES >> 1)
                                           >> page_ff[OFF_W-1:0]);
            state_in         = S_RESP;
         end
         S_SCAN: begin
            if (hit.found) begin
               if (hit_page > mem_last_page) begin
                  res_status_in = STATUS_FAIL;
               end else begin
                  map_port.wr_en   = 1'b1;
                  map_port.wr_addr = word_ff;
                  map_port.wr_data = rd_data | ((WORD_ONES & ~(WORD_ONES >> 1)) >> hit.off);
                  res_page_in      = hit_page;
               end
               state_in = S_RESP;
            end else if (word_ff == WORD_W'(MAP_WORDS - 1)) begin
               res_status_in = STATUS_FAIL;
               state_in      = S_RESP;
            end else begin
               // advance to the next word
               word_in          = word_ff + WORD_W'(1);
               map_port.rd_en   = 1'b1;
               map_port.rd_addr = word_ff + WORD_W'(1);
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      word_ff       <= word_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.alloc_page = rsp_page_ff;

endmodule

`default_nettype wire

/* hw/rtl/page_frame_bitmap_allocator_core.sv */
`default_nettype none

// Page frame allocator over a 512-page used-bitmap kept in one 16 x 32-bit
// map memory, page p at word p/32, bit 31 - p%32. An allocate request returns
// the lowest free page above os_last_page and marks it used, or status 1 with
// page 0 when none is free or the one found lies above mem_last_page; a free
// request clears the page's bit and returns status 0, page 0. The map reads
// as all free after reset. An allocate reads k map words, k from 0 to 16, one
// word per cycle through the single read port; k is 0 when os_last_page is
// the last page of the map. The sequencer moves a result into the output
// register once that register is free, and the result may wait there while
// the next request is taken.
module page_frame_bitmap_allocator_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   pfba_req_if.sink                          req_chan,
   pfba_rsp_if.source                        rsp_chan,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [pfba_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [pfba_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [pfba_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import pfba_pkg::*;

   logic [PAGE_W-1:0]    os_last_page;
   logic [PAGE_W-1:0]    mem_last_page;
   map_port_type         map_port;
   logic [WORD_BITS-1:0] rd_data;

   pfba_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .os_last_page  (os_last_page),
      .mem_last_page (mem_last_page)
   );

   pfba_map_ram u_map_ram (
      .clock    (clock),
      .reset    (reset),
      .map_port (map_port),
      .rd_data  (rd_data)
   );

   pfba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .os_last_page  (os_last_page),
      .mem_last_page (mem_last_page),
      .map_port      (map_port),
      .rd_data       (rd_data)
   );

`ifndef NO_ASSERTIONS
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(map_port.rd_en && map_port.wr_en && map_port.rd_addr == map_port.wr_addr))
      else $error("map read and write to the same word in one cycle");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !map_port.wr_en)
      else $error("map write while taking a new request");

   a_fail_zero_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_FAIL) |-> rsp_chan.alloc_page == '0)
      else $error("failed allocate carries a nonzero page");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.alloc_page != '0) |->
         (rsp_chan.alloc_page > os_last_page && rsp_chan.alloc_page <= mem_last_page))
      else $error("granted page outside the allocatable range");
`endif

endmodule

`default_nettype wire
